// File: rtl/core/cvpl_pkg.sv
// Shared constants, codes and types of the converter voltage PI loop.
package cvpl_pkg;

    // Field and port widths.
    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 15;
    localparam int DUTY_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int S_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Millivolt scaling: 18000/4095 reduces to 400/91. The quotient
    // floor(sample*400/91) is exact as floor(sample*MV_RECIP >> MV_SHIFT)
    // because the rounding excess of MV_RECIP times the largest sample
    // stays below 2**MV_SHIFT.
    localparam int MV_NUM      = 18000 / 45;
    localparam int MV_DEN      = 4095 / 45;
    localparam int MV_SHIFT    = 19;
    localparam int MV_RECIP    = (MV_NUM * (2 ** MV_SHIFT) + MV_DEN - 1) / MV_DEN;
    localparam int MV_RECIP_W  = $clog2(MV_RECIP + 1);
    localparam int PROD_W      = SAMPLE_W + MV_RECIP_W;

    // Regulation target and the window for the ready flag, in millivolts.
    localparam int MV_TARGET   = 12000;
    localparam int MV_READY_LO = 10000;
    localparam int MV_READY_HI = 14000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD_MAX  = 1'b0,
        CFG_LOOP_DUTY_LIMIT = 1'b1
    } cfg_index_t;

    // Duty accumulator, 16-bit two's complement.
    typedef logic signed [DUTY_W-1:0] acc_t;

    // What one loop step hands to the output side.
    typedef struct packed {
        acc_t acc;
        logic voltage_ready;
    } loop_result_t;

endpackage

// File: rtl/core/cvpl_loop_core.sv
// Loop state and update: error term, accumulator step and clamp.
module cvpl_loop_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [cvpl_pkg::MV_W-1:0]     millivolts,
    input  logic [cvpl_pkg::LIMIT_W-1:0]  loop_duty_limit,
    output cvpl_pkg::loop_result_t        result
);
    import cvpl_pkg::*;

    localparam int ERR_W = MV_W + 3;
    localparam int Q_W   = DUTY_W - 4;

    logic [MV_W-1:0]           prev_mv_reg;
    acc_t                      acc_reg;
    logic signed [ERR_W-1:0]   mv_s;
    logic signed [ERR_W-1:0]   prev_s;
    logic signed [ERR_W-1:0]   err_full;
    logic signed [DUTY_W-1:0]  err16;
    logic signed [DUTY_W-1:0]  err_biased;
    logic signed [Q_W-1:0]     quot;
    acc_t                      acc_diff;
    acc_t                      upper;
    acc_t                      lower;
    acc_t                      acc_next;
    logic                      ready_flag;

    // Error plus twice the change, wrapped to 16 bits.
    always_comb begin
        mv_s     = $signed({3'b000, millivolts});
        prev_s   = $signed({3'b000, prev_mv_reg});
        err_full = mv_s - $signed(ERR_W'(MV_TARGET)) + ((mv_s - prev_s) <<< 1);
        err16    = err_full[DUTY_W-1:0];
    end

    // Divide by 16 toward zero: bias negative values before the shift.
    always_comb begin
        err_biased = err16 + (err16[DUTY_W-1] ? 16'sd15 : 16'sd0);
        quot       = err_biased[DUTY_W-1:4];
    end

    // Accumulator step wraps in 16 bits, then clamps to [-limit/4, limit].
    always_comb begin
        acc_diff = acc_reg - {{4{quot[Q_W-1]}}, quot};
        upper    = $signed({1'b0, loop_duty_limit});
        lower    = -$signed({3'b000, loop_duty_limit[LIMIT_W-1:2]});
        acc_next = acc_diff;
        if (acc_next > upper) begin
            acc_next = upper;
        end
        if (acc_next < lower) begin
            acc_next = lower;
        end
    end

    // Ready window check on the fresh sample.
    assign ready_flag = (millivolts >= MV_W'(MV_READY_LO)) &&
                        (millivolts <= MV_W'(MV_READY_HI));

    assign result = '{acc: acc_next, voltage_ready: ready_flag};

    // State advances once per word that leaves this stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mv_reg <= '0;
            acc_reg     <= '0;
        end else if (step) begin
            prev_mv_reg <= millivolts;
            acc_reg     <= acc_next;
        end
    end

endmodule

// File: rtl/core/converter_voltage_pi_loop_unit.sv
// Top level of the converter voltage PI loop: scaling, loop step and duty output.
//
//  Channel  | Direction | Handshake            | Contents
//  ---------+-----------+----------------------+------------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tdata: adc_sample
//  m_       | out       | m_tvalid / m_tready  | m_tdata: duty_compare, m_tuser: ready
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One word per cycle is accepted; each sample passes through four registered
// stages in order: input register, millivolt multiply, loop update, duty register.
// The loop state updates in a single stage, so words never wait on each other.
// A stall on m_ only blocks s_ once all four stages hold a word.
// Synchronous active-low reset clears valids, loop state and config registers.
module converter_voltage_pi_loop_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cvpl_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] adc_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cvpl_pkg::DUTY_W-1:0]      m_tdata,   // [15:0] duty_compare
    output logic                             m_tuser,   // [0] voltage_ready
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  cvpl_pkg::cfg_index_t             cfg_index,
    input  logic [cvpl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cvpl_pkg::*;

    logic [DUTY_W-1:0]   period_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                a_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                b_valid_reg;
    logic [MV_W-1:0]     mv_reg;
    logic                c_valid_reg;
    loop_result_t        c_res_reg;
    logic                o_valid_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic                ready_reg;
    logic                en_o;
    logic                en_c;
    logic                en_b;
    logic                en_a;
    logic [PROD_W-1:0]   mv_prod;
    loop_result_t        loop_res;
    logic [DUTY_W-1:0]   duty_next;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            limit_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PWM_PERIOD_MAX:  period_reg <= cfg_wdata;
                CFG_LOOP_DUTY_LIMIT: limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when it drains this cycle.
    assign en_o     = !o_valid_reg || m_tready;
    assign en_c     = !c_valid_reg || en_o;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a && s_tvalid) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // Millivolt scaling by a constant reciprocal.
    assign mv_prod = PROD_W'(sample_reg) * PROD_W'(MV_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b && a_valid_reg) begin
            mv_reg <= mv_prod[MV_SHIFT +: MV_W];
        end
    end

    // Loop update; state moves with the word leaving stage B.
    cvpl_loop_core u_loop (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (en_c && b_valid_reg),
        .millivolts      (mv_reg),
        .loop_duty_limit (limit_reg),
        .result          (loop_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c && b_valid_reg) begin
            c_res_reg <= loop_res;
        end
    end

    // Duty: zero when not positive, period plus one above the period.
    always_comb begin
        if (c_res_reg.acc <= 0) begin
            duty_next = '0;
        end else if ($unsigned(c_res_reg.acc) > period_reg) begin
            duty_next = period_reg + 16'd1;
        end else begin
            duty_next = $unsigned(c_res_reg.acc);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en_o) begin
            o_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_o && c_valid_reg) begin
            duty_reg  <= duty_next;
            ready_reg <= c_res_reg.voltage_ready;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = duty_reg;
    assign m_tuser  = ready_reg;

    // The clamped accumulator held for output respects the configured limits.
    a_acc_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |->
            (c_res_reg.acc <= $signed({1'b0, limit_reg})) &&
            (c_res_reg.acc >= -$signed({3'b000, limit_reg[LIMIT_W-1:2]})))
        else $error("duty accumulator outside its clamp range");

    // A delivered duty never exceeds the period plus one.
    a_duty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata} <= ({1'b0, period_reg} + 17'd1)))
        else $error("duty above period plus one");

    // Input is refused only when every stage is occupied and the output stalls.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (a_valid_reg && b_valid_reg && c_valid_reg &&
                       o_valid_reg && !m_tready))
        else $error("input refused while the pipeline has room");

    // A loop step always leaves its word in stage C.
    a_c_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && en_c) |=> c_valid_reg)
        else $error("loop step lost its word");

endmodule
